[hw/rtl/lrap_pkg.sv]
// Package: types, codes and character helpers for the line range parser.
`default_nettype none
package lrap_pkg;

	typedef enum logic [3:0] {
		PH_LEAD,
		PH_TAIL,
		PH_ADDR,
		PH_NUM,
		PH_PAT,
		PH_PRE,
		PH_SIGN,
		PH_DIG,
		PH_COMMA,
		PH_IGN,
		PH_END
	} phase_t;

	localparam logic [2:0] TAG_NONE  = 3'd0;
	localparam logic [2:0] TAG_CUR   = 3'd1;
	localparam logic [2:0] TAG_LAST  = 3'd2;
	localparam logic [2:0] TAG_NUM   = 3'd3;
	localparam logic [2:0] TAG_SRCH  = 3'd4;
	localparam logic [2:0] TAG_PREV  = 3'd5;
	localparam logic [2:0] TAG_FIRST = 3'd6;

	localparam logic [1:0] ERR_OK     = 2'd0;
	localparam logic [1:0] ERR_OFFSET = 2'd1;
	localparam logic [1:0] ERR_NUMBER = 2'd2;
	localparam logic [1:0] ERR_BASE   = 2'd3;

	localparam logic [5:0] BASE_DEC   = 6'd10;
	localparam logic [5:0] BASE_ALNUM = 6'd36;
	localparam logic [5:0] BASE_RESET = 6'd10;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DOLR  = 8'h24;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	localparam logic [32:0] OFF_CAP     = 33'h1_0000_0000;
	localparam logic [32:0] OFF_NEG_MAX = 33'h0_8000_0000;
	localparam logic [32:0] OFF_POS_MAX = 33'h0_7FFF_FFFF;

	typedef struct packed {
		logic               go;
		logic [7:0]         ch;
	} step_t;

	typedef struct packed {
		logic [2:0]         first_tag;
		logic [31:0]        first_number;
		logic signed [31:0] first_offset;
		logic [15:0]        first_pattern_start;
		logic [15:0]        first_pattern_length;
		logic [2:0]         second_tag;
		logic [31:0]        second_number;
		logic signed [31:0] second_offset;
		logic [15:0]        consumed_length;
		logic [1:0]         error_code;
	} res_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// {valid, value}
	function automatic logic [4:0] dec_digit(input logic [7:0] c);
		logic [7:0] t;
		t = c - 8'h30;
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, t[3:0]};
		return 5'd0;
	endfunction

	function automatic logic [6:0] base_digit(input logic [7:0] c, input logic [5:0] base);
		logic [7:0] t;
		t = 8'd0;
		if (base == BASE_DEC || base == BASE_ALNUM) begin
			if (c >= 8'h30 && c <= 8'h39) begin
				t = c - 8'h30;
				return {1'b1, t[5:0]};
			end
		end
		if (base == BASE_ALNUM) begin
			if (c >= 8'h61 && c <= 8'h7A) begin
				t = c - 8'h61 + 8'd10;
				return {1'b1, t[5:0]};
			end
			if (c >= 8'h41 && c <= 8'h5A) begin
				t = c - 8'h41 + 8'd10;
				return {1'b1, t[5:0]};
			end
		end
		return 7'd0;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/line_range_address_parser_unit.sv]
// Top level: ed line range parser, one character per item, one result per command.
// Usage:
//   The input channel (in_valid, in_stall, character) takes one command byte per
//   item; a byte of 0 ends the command. The output channel (out_valid, out_stall
//   and the result fields) gives one item per command, as soon as the range is
//   decided; later bytes are dropped up to and including the 0.
//   cfg_valid/cfg_ready with number_base sets the line number radix (10 or 36);
//   write it only while the block is idle. cfg_ready is always high.
//   The byte that ends the range passes the input register, then its result is
//   loaded into the result register.
//   Throughput: one byte per cycle unless the output stalls; the parse step is
//   one pass of logic between the input register and the state/result registers.
//   While out_stall holds a full result register, the byte in the input
//   register waits and in_stall rises; bytes that give no result still wait.
//   Reset clears the parse state, empties both registers and sets the radix
//   to 10.
`default_nettype none
module line_range_address_parser_unit import lrap_pkg::*; #(
	parameter int POSITION_BITS = 16,
	parameter int LINE_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [5:0]  number_base,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  character,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       first_tag,
	output logic [31:0]      first_number,
	output logic signed [31:0] first_offset,
	output logic [15:0]      first_pattern_start,
	output logic [15:0]      first_pattern_length,
	output logic [2:0]       second_tag,
	output logic [31:0]      second_number,
	output logic signed [31:0] second_offset,
	output logic [15:0]      consumed_length,
	output logic [1:0]       error_code
);
	logic [5:0] base_q;
	logic       v_s1, proceed, emit;
	logic [7:0] ch_s1;
	step_t      st;
	res_t       res, res_out;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_valid) begin
			base_q <= number_base;
		end
	end

	assign proceed = !(out_valid && out_stall);
	assign in_stall = v_s1 && !proceed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			v_s1 <= 1'b1;
		end else if (proceed) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1 <= character;
		end
	end

	assign st.go = v_s1 && proceed;
	assign st.ch = ch_s1;

	lrap_core #(.POSITION_BITS(POSITION_BITS), .LINE_BITS(LINE_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .st(st), .base(base_q), .emit(emit), .res(res)
	);

	lrap_out_reg u_out (
		.clk(clk), .arst_n(arst_n), .load(emit), .din(res), .stall(out_stall),
		.valid(out_valid), .dout(res_out)
	);

	assign first_tag = res_out.first_tag;
	assign first_number = res_out.first_number;
	assign first_offset = res_out.first_offset;
	assign first_pattern_start = res_out.first_pattern_start;
	assign first_pattern_length = res_out.first_pattern_length;
	assign second_tag = res_out.second_tag;
	assign second_number = res_out.second_number;
	assign second_offset = res_out.second_offset;
	assign consumed_length = res_out.consumed_length;
	assign error_code = res_out.error_code;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with an empty result register");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code != ERR_OK) |-> (first_tag == TAG_NONE && consumed_length == 16'd0))
		else $error("error result carries fields");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && first_tag != TAG_SRCH) |->
		(first_pattern_start == 16'd0 && first_pattern_length == 16'd0))
		else $error("pattern fields without a search address");

endmodule
`default_nettype wire

[hw/rtl/lrap_core.sv]
// Parser state and per-character step logic.
`default_nettype none
module lrap_core import lrap_pkg::*; #(
	parameter int POSITION_BITS = 16,
	parameter int LINE_BITS = 32
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire step_t      st,
	input  wire logic [5:0] base,
	output logic            emit,
	output res_t            res
);
	localparam int PB = POSITION_BITS;
	localparam int LB = LINE_BITS;
	localparam int LW = LINE_BITS + 6;

	phase_t          phase_q, ph;
	logic            slot_q, slot_d;
	logic [PB-1:0]   pos_q, pos_d, mark_q, mark_d, fps_q, fps_d, fpl_q, fpl_d, p, cons;
	logic [LB-1:0]   nacc_q, nacc_d, fnum_q, fnum_d, snum_q, snum_d;
	logic            novf_q, novf_d, oneg_q, oneg_d;
	logic [32:0]     oacc_q, oacc_d;
	logic [2:0]      ftag_q, ftag_d, stag_q, stag_d;
	logic [31:0]     foff_q, foff_d, soff_q, soff_d, offv;
	logic [LW-1:0]   nprod;
	logic [36:0]     oprod;
	logic [6:0]      bd;
	logic [4:0]      dd;
	logic [1:0]      err;
	logic            run, restart;
	logic [7:0]      c;
	logic [PB+15:0]  w16a, w16b, w16c;
	logic [LB+31:0]  w32a, w32b;

	always_comb begin
		ph = phase_q; slot_d = slot_q; pos_d = pos_q; mark_d = mark_q;
		fps_d = fps_q; fpl_d = fpl_q; nacc_d = nacc_q; novf_d = novf_q;
		oacc_d = oacc_q; oneg_d = oneg_q; ftag_d = ftag_q; fnum_d = fnum_q;
		foff_d = foff_q; stag_d = stag_q; snum_d = snum_q; soff_d = soff_q;
		emit = 1'b0; err = ERR_OK; cons = '0; run = 1'b0; restart = 1'b0;
		c = st.ch; p = pos_q;
		bd = base_digit(c, base); dd = dec_digit(c);
		nprod = LW'(nacc_q) * LW'(base) + LW'(bd[5:0]);
		oprod = 37'(oacc_q) * 37'd10 + 37'(dd[3:0]);
		offv = oneg_q ? (32'd0 - oacc_q[31:0]) : oacc_q[31:0];
		if (st.go) begin
			if (pos_q != {PB{1'b1}}) pos_d = pos_q + 1'b1;
			run = 1'b1;
			for (int i = 0; i < 5; i++) begin
				if (run) begin
					case (ph)
						PH_LEAD: begin
							if (is_space(c)) run = 1'b0;
							else if (c == CH_NUL) begin
								emit = 1'b1; cons = p; run = 1'b0;
							end else if (c == CH_CARET) begin
								ftag_d = TAG_PREV; stag_d = TAG_PREV; ph = PH_TAIL; run = 1'b0;
							end else if (c == CH_PCT) begin
								ftag_d = TAG_FIRST; stag_d = TAG_LAST; ph = PH_TAIL; run = 1'b0;
							end else if (c == CH_COMMA) begin
								ftag_d = TAG_CUR; fnum_d = LB'(1); slot_d = 1'b1;
								ph = PH_ADDR; run = 1'b0;
							end else begin
								slot_d = 1'b0; ph = PH_ADDR;
							end
						end
						PH_TAIL: begin
							if (!is_space(c)) begin
								emit = 1'b1; cons = p;
							end
							run = 1'b0;
						end
						PH_ADDR: begin
							run = 1'b0;
							if (base != BASE_DEC && base != BASE_ALNUM) begin
								emit = 1'b1; err = ERR_BASE;
							end else begin
								if (slot_d) begin
									stag_d = TAG_NONE; snum_d = '0; soff_d = '0;
								end else begin
									ftag_d = TAG_NONE; fnum_d = '0; foff_d = '0;
								end
								if (c == CH_SLASH) begin
									if (slot_d) stag_d = TAG_SRCH;
									else begin
										ftag_d = TAG_SRCH;
										fps_d = (p != {PB{1'b1}}) ? p + 1'b1 : p;
									end
									ph = PH_PAT;
								end else if (c == CH_DOT || c == CH_DOLR) begin
									if (slot_d) stag_d = (c == CH_DOT) ? TAG_CUR : TAG_LAST;
									else ftag_d = (c == CH_DOT) ? TAG_CUR : TAG_LAST;
									ph = PH_PRE;
								end else if (c == CH_PLUS || c == CH_MINUS) begin
									if (slot_d) stag_d = TAG_CUR;
									else ftag_d = TAG_CUR;
									oneg_d = (c == CH_MINUS); oacc_d = '0; ph = PH_SIGN;
								end else if (bd[6]) begin
									if (slot_d) stag_d = TAG_NUM;
									else ftag_d = TAG_NUM;
									nacc_d = LB'(bd[5:0]); novf_d = 1'b0; ph = PH_NUM;
								end else begin
									emit = 1'b1; cons = p;
								end
							end
						end
						PH_NUM: begin
							if (bd[6]) begin
								if (nprod[LW-1:LB] != '0) novf_d = 1'b1;
								else nacc_d = nprod[LB-1:0];
								run = 1'b0;
							end else if (novf_q) begin
								emit = 1'b1; err = ERR_NUMBER; run = 1'b0;
							end else begin
								if (slot_d) snum_d = nacc_q;
								else fnum_d = nacc_q;
								ph = PH_PRE;
							end
						end
						PH_PAT: begin
							if (c == CH_SLASH || c == CH_NUL) begin
								if (!slot_d) fpl_d = p - fps_q + 1'b1;
								if (c == CH_SLASH) begin
									ph = PH_PRE; run = 1'b0;
								end else ph = PH_END;
							end else run = 1'b0;
						end
						PH_PRE: begin
							if (is_space(c)) run = 1'b0;
							else if (c == CH_PLUS || c == CH_MINUS) begin
								oneg_d = (c == CH_MINUS); oacc_d = '0; ph = PH_SIGN; run = 1'b0;
							end else ph = PH_END;
						end
						PH_SIGN: begin
							if (dd[4]) begin
								oacc_d = 33'(dd[3:0]); ph = PH_DIG; run = 1'b0;
							end else begin
								if (slot_d) soff_d = oneg_q ? '1 : 32'd1;
								else foff_d = oneg_q ? '1 : 32'd1;
								ph = PH_END;
							end
						end
						PH_DIG: begin
							if (dd[4]) begin
								oacc_d = (oprod > 37'(OFF_CAP)) ? OFF_CAP : oprod[32:0];
								run = 1'b0;
							end else if (oneg_q ? (oacc_q > OFF_NEG_MAX) : (oacc_q > OFF_POS_MAX)) begin
								emit = 1'b1; err = ERR_OFFSET; run = 1'b0;
							end else begin
								if (slot_d) soff_d = offv;
								else foff_d = offv;
								ph = PH_END;
							end
						end
						PH_END: begin
							if (!slot_d) begin
								mark_d = p; ph = PH_COMMA;
							end else begin
								emit = 1'b1; cons = p; run = 1'b0;
							end
						end
						PH_COMMA: begin
							run = 1'b0;
							if (c == CH_COMMA) begin
								slot_d = 1'b1; ph = PH_ADDR;
							end else if (!is_space(c)) begin
								emit = 1'b1; cons = mark_d;
							end
						end
						default: begin
							run = 1'b0;
							if (c == CH_NUL) restart = 1'b1;
						end
					endcase
				end
			end
			if (emit) begin
				if (c == CH_NUL) restart = 1'b1;
				else ph = PH_IGN;
			end
		end
	end

	always_comb begin
		w16a = {16'd0, fps_d};
		w16b = {16'd0, fpl_d};
		w16c = {16'd0, cons};
		w32a = {32'd0, fnum_d};
		w32b = {32'd0, snum_d};
		res = '0;
		res.error_code = err;
		if (err == ERR_OK) begin
			res.first_tag = ftag_d;
			res.first_number = w32a[31:0];
			res.first_offset = foff_d;
			if (ftag_d == TAG_SRCH) begin
				res.first_pattern_start = w16a[15:0];
				res.first_pattern_length = w16b[15:0];
			end
			res.second_tag = stag_d;
			res.second_number = w32b[31:0];
			res.second_offset = soff_d;
			res.consumed_length = w16c[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD; slot_q <= 1'b0; pos_q <= '0; mark_q <= '0;
			fps_q <= '0; fpl_q <= '0; nacc_q <= '0; novf_q <= 1'b0;
			oacc_q <= '0; oneg_q <= 1'b0; ftag_q <= TAG_NONE; fnum_q <= '0;
			foff_q <= '0; stag_q <= TAG_NONE; snum_q <= '0; soff_q <= '0;
		end else if (restart) begin
			phase_q <= PH_LEAD; slot_q <= 1'b0; pos_q <= '0; mark_q <= '0;
			fps_q <= '0; fpl_q <= '0; nacc_q <= '0; novf_q <= 1'b0;
			oacc_q <= '0; oneg_q <= 1'b0; ftag_q <= TAG_NONE; fnum_q <= '0;
			foff_q <= '0; stag_q <= TAG_NONE; snum_q <= '0; soff_q <= '0;
		end else begin
			phase_q <= ph; slot_q <= slot_d; pos_q <= pos_d; mark_q <= mark_d;
			fps_q <= fps_d; fpl_q <= fpl_d; nacc_q <= nacc_d; novf_q <= novf_d;
			oacc_q <= oacc_d; oneg_q <= oneg_d; ftag_q <= ftag_d; fnum_q <= fnum_d;
			foff_q <= foff_d; stag_q <= stag_d; snum_q <= snum_d; soff_q <= soff_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> st.go)
		else $error("result without a step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(st.go && phase_q == PH_IGN) |-> !emit)
		else $error("second result in one command");
	assert property (@(posedge clk) disable iff (!arst_n)
		!st.go |=> $stable(pos_q) || pos_q == '0)
		else $error("position moved while idle");

endmodule
`default_nettype wire

[hw/rtl/lrap_out_reg.sv]
// Result register with valid/stall handshake.
`default_nettype none
module lrap_out_reg import lrap_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire res_t din,
	input  wire logic stall,
	output logic      valid,
	output res_t      dout
);
	logic valid_q;
	res_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= din;
		end
	end

	assign valid = valid_q;
	assign dout = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || !stall))
		else $error("result overwritten while stalled");

endmodule
`default_nettype wire
